>>> rtl/core/csstok_pkg.sv
package csstok_pkg;

   localparam int HOLD_DEPTH = 16;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
   localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;

   localparam logic [1:0] KIND_SEL   = 2'd0;
   localparam logic [1:0] KIND_PROP  = 2'd1;
   localparam logic [1:0] KIND_VALUE = 2'd2;

   localparam logic [1:0] MARK_DATA  = 2'd0;
   localparam logic [1:0] MARK_TOKEN = 2'd1;
   localparam logic [1:0] MARK_RULE  = 2'd2;
   localparam logic [1:0] MARK_MALF  = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] token_kind;
      logic [1:0] marker;
      logic       pending_overflow;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic             flush;
      logic [CNT_W-1:0] cnt;
      logic             ovf;
      logic [7:0]       chr;
      logic [1:0]       kind;
      logic [1:0]       marker;
      logic             rule_end;
   } cmd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } hold_wr_type;

endpackage

>>> rtl/core/csstok_front.sv
module csstok_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  csstok_pkg::req_type     req_data,
   input  logic                   q_full,
   output logic                   push,
   output csstok_pkg::cmd_type     cmd,
   output csstok_pkg::hold_wr_type hold_wr,
   input  logic                   flush_done
);
   import csstok_pkg::*;

   typedef enum logic [2:0] {
      PH_BETWEEN = 3'd0,
      PH_RULE    = 3'd1,
      PH_DSKIP   = 3'd2,
      PH_PROP    = 3'd3,
      PH_VSKIP   = 3'd4,
      PH_VAL     = 3'd5,
      PH_STR     = 3'd6
   } phase_type;

   phase_type        phase_ff, phase_in, phase_mid;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             dropped_ff, dropped_in;
   logic             busy_ff;
   logic             accept, ws, has_cmd, hold_req, drop_req, flush_req, end_val;
   logic [7:0]       c;
   cmd_type          cmd_c;

   assign c         = req_data.in_byte;
   assign req_ready = !q_full && !busy_ff;
   assign accept    = req_valid && req_ready;
   assign ws        = (c == CH_NL) || (c == CH_SPACE) || (c == CH_TAB);

   always_comb begin
      phase_mid = phase_ff;
      has_cmd   = 1'b0;
      hold_req  = 1'b0;
      drop_req  = 1'b0;
      flush_req = 1'b0;
      end_val   = 1'b0;
      cmd_c     = '0;
      unique case (phase_ff)
         PH_BETWEEN: begin
            if (!ws) begin
               has_cmd = 1'b1;
               cmd_c.kind = KIND_SEL;
               if (c == CH_LBRACE) begin
                  cmd_c.marker = MARK_TOKEN;
                  phase_mid = PH_DSKIP;
               end else begin
                  cmd_c.chr = c;
                  phase_mid = PH_RULE;
               end
            end
         end
         PH_RULE: begin
            if (ws) begin
               hold_req = 1'b1;
            end else if (c == CH_LBRACE) begin
               drop_req = 1'b1;
               has_cmd = 1'b1;
               cmd_c.kind = KIND_SEL;
               cmd_c.marker = MARK_TOKEN;
               phase_mid = PH_DSKIP;
            end else begin
               flush_req = 1'b1;
               has_cmd = 1'b1;
               cmd_c.kind = KIND_SEL;
               cmd_c.chr = c;
            end
         end
         PH_DSKIP: begin
            if (!ws) begin
               has_cmd = 1'b1;
               if (c == CH_RBRACE) begin
                  cmd_c.kind = KIND_SEL;
                  cmd_c.marker = MARK_RULE;
                  phase_mid = PH_BETWEEN;
               end else if (c == CH_COLON) begin
                  cmd_c.kind = KIND_PROP;
                  cmd_c.marker = MARK_TOKEN;
                  phase_mid = PH_VSKIP;
               end else begin
                  cmd_c.kind = KIND_PROP;
                  cmd_c.chr = c;
                  phase_mid = PH_PROP;
               end
            end
         end
         PH_PROP: begin
            if (ws) begin
               hold_req = 1'b1;
            end else if (c == CH_COLON) begin
               drop_req = 1'b1;
               has_cmd = 1'b1;
               cmd_c.kind = KIND_PROP;
               cmd_c.marker = MARK_TOKEN;
               phase_mid = PH_VSKIP;
            end else begin
               flush_req = 1'b1;
               has_cmd = 1'b1;
               cmd_c.kind = KIND_PROP;
               cmd_c.chr = c;
            end
         end
         PH_VSKIP: begin
            if (!ws) begin
               has_cmd = 1'b1;
               if ((c == CH_SEMI) || (c == CH_RBRACE)) begin
                  end_val = 1'b1;
               end else begin
                  cmd_c.kind = KIND_VALUE;
                  cmd_c.chr = c;
                  phase_mid = (c == CH_QUOTE) ? PH_STR : PH_VAL;
               end
            end
         end
         PH_VAL: begin
            if (ws) begin
               hold_req = 1'b1;
            end else if ((c == CH_SEMI) || (c == CH_RBRACE)) begin
               has_cmd = 1'b1;
               end_val = 1'b1;
            end else begin
               flush_req = 1'b1;
               has_cmd = 1'b1;
               cmd_c.kind = KIND_VALUE;
               cmd_c.chr = c;
               if (c == CH_QUOTE) begin
                  phase_mid = PH_STR;
               end
            end
         end
         PH_STR: begin
            has_cmd = 1'b1;
            cmd_c.kind = KIND_VALUE;
            cmd_c.chr = c;
            if (c == CH_QUOTE) begin
               phase_mid = PH_VAL;
            end
         end
         default: begin
            drop_req = 1'b1;
            phase_mid = PH_BETWEEN;
         end
      endcase

      if (end_val) begin
         drop_req = 1'b1;
         cmd_c.kind = KIND_VALUE;
         cmd_c.marker = MARK_TOKEN;
         cmd_c.rule_end = (c == CH_RBRACE);
         phase_mid = (c == CH_RBRACE) ? PH_BETWEEN : PH_DSKIP;
      end

      if (flush_req) begin
         cmd_c.flush = 1'b1;
         cmd_c.cnt = cnt_ff;
         cmd_c.ovf = dropped_ff;
      end

      cnt_in = cnt_ff;
      dropped_in = dropped_ff;
      hold_wr = '0;
      hold_wr.addr = cnt_ff[IDX_W-1:0];
      hold_wr.data = c;
      if (hold_req) begin
         if (cnt_ff < CNT_W'(HOLD_DEPTH)) begin
            hold_wr.en = accept;
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (drop_req || flush_req) begin
         cnt_in = '0;
         dropped_in = 1'b0;
      end

      phase_in = phase_mid;
      if (req_data.end_of_text) begin
         if (phase_mid != PH_BETWEEN) begin
            has_cmd = 1'b1;
            cmd_c = '0;
            cmd_c.marker = MARK_MALF;
            if (phase_mid == PH_RULE) begin
               cmd_c.kind = KIND_SEL;
            end else if ((phase_mid == PH_DSKIP) || (phase_mid == PH_PROP)) begin
               cmd_c.kind = KIND_PROP;
            end else begin
               cmd_c.kind = KIND_VALUE;
            end
         end
         phase_in = PH_BETWEEN;
         cnt_in = '0;
         dropped_in = 1'b0;
      end
   end

   assign cmd  = cmd_c;
   assign push = accept && has_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BETWEEN;
         cnt_ff     <= '0;
         dropped_ff <= 1'b0;
         busy_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            cnt_ff     <= cnt_in;
            dropped_ff <= dropped_in;
         end
         if (push && cmd_c.flush && (cmd_c.cnt != '0)) begin
            busy_ff <= 1'b1;
         end else if (flush_done) begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

>>> rtl/core/csstok_queue.sv
module csstok_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csstok_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output csstok_pkg::cmd_type head_data
);
   import csstok_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

>>> rtl/core/csstok_back.sv
module csstok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  csstok_pkg::cmd_type     head_data,
   output logic                   pop,
   input  csstok_pkg::hold_wr_type hold_wr,
   output logic                   flush_done,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csstok_pkg::rsp_type     rsp_data
);
   import csstok_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'd0,
      B_READ = 3'd1,
      B_HOLD = 3'd2,
      B_MAIN = 3'd3,
      B_RULE = 3'd4
   } back_state_type;

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       mem [HOLD_DEPTH];
   logic [7:0]       rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             slot_free, last_held, fire;
   logic [7:0]       held_chr;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign last_held  = ((CNT_W'(idx_ff) + CNT_W'(1)) == cmd_ff.cnt);
   assign held_chr   = ((cmd_ff.kind == KIND_SEL) && (rd_ff == CH_NL)) ? CH_SPACE : rd_ff;
   assign flush_done = (state_ff == B_HOLD) && slot_free && last_held;
   assign pop        = head_valid && ((state_ff == B_IDLE) ||
                       ((state_ff == B_MAIN) && slot_free && !cmd_ff.rule_end) ||
                       ((state_ff == B_RULE) && slot_free));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (hold_wr.en) begin
         mem[hold_wr.addr] <= hold_wr.data;
      end
      rd_ff <= mem[idx_ff];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      fire     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
         end
         B_READ: begin
            state_in = B_HOLD;
         end
         B_HOLD: begin
            if (slot_free) begin
               fire = 1'b1;
               rsp_in = '{out_byte: held_chr, token_kind: cmd_ff.kind,
                          marker: MARK_DATA, pending_overflow: cmd_ff.ovf,
                          last_of_run: 1'b0};
               idx_in = idx_ff + IDX_W'(1);
               state_in = last_held ? B_MAIN : B_READ;
            end
         end
         B_MAIN: begin
            if (slot_free) begin
               fire = 1'b1;
               rsp_in = '{out_byte: cmd_ff.chr, token_kind: cmd_ff.kind,
                          marker: cmd_ff.marker, pending_overflow: cmd_ff.ovf,
                          last_of_run: !cmd_ff.rule_end};
               state_in = cmd_ff.rule_end ? B_RULE : B_IDLE;
            end
         end
         B_RULE: begin
            if (slot_free) begin
               fire = 1'b1;
               rsp_in = '{out_byte: 8'd0, token_kind: KIND_SEL,
                          marker: MARK_RULE, pending_overflow: 1'b0,
                          last_of_run: 1'b1};
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (pop) begin
         idx_in = '0;
         state_in = (head_data.flush && (head_data.cnt != '0)) ? B_READ : B_MAIN;
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         rsp_ff       <= rsp_in;
         if (pop) begin
            cmd_ff <= head_data;
         end
      end
   end

endmodule

>>> rtl/core/css_rule_declaration_tokenizer.sv
// A result reaches the output register through the queue entry and the back end's
// command register; a byte that first flushes held whitespace waits behind the held bytes.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// is not stalled; a value closed by '}' also gives a rule-end result, and a whitespace
// flush of N held bytes adds N results. Input stalls after it until the last is sent.
// Synchronous reset clears phase, hold count, queue and output stage, not the hold buffer.
module css_rule_declaration_tokenizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  csstok_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output csstok_pkg::rsp_type rsp_data
);
   import csstok_pkg::*;

   logic        q_full, push, pop, head_valid, flush_done;
   cmd_type     cmd, head_data;
   hold_wr_type hold_wr;

   csstok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .cmd        (cmd),
      .hold_wr    (hold_wr),
      .flush_done (flush_done)
   );

   csstok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   csstok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .hold_wr    (hold_wr),
      .flush_done (flush_done),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/core/csstok_checker.sv
module csstok_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input csstok_pkg::rsp_type rsp_data
);
   import csstok_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.marker != MARK_DATA) |-> (rsp_data.out_byte == 8'd0))
      else $error("marker result carries a byte");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.marker == MARK_RULE) || (rsp_data.marker == MARK_MALF))
      |-> rsp_data.last_of_run)
      else $error("rule end or malformed end not last of run");

   a_ovf_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pending_overflow |-> (rsp_data.marker == MARK_DATA))
      else $error("overflow flag on a marker");

   a_rule_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.marker == MARK_RULE) |-> (rsp_data.token_kind == KIND_SEL))
      else $error("rule end with wrong kind");

endmodule

bind css_rule_declaration_tokenizer csstok_checker u_csstok_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
